@@ design/sgg_pkg.sv @@
`timescale 1ns / 1ps
// sgg_pkg: constants, codes and types of the separable Gaussian gradient block.
// No dependencies.
package sgg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_TAPS   = 15;
  localparam int MAX_HEIGHT = 4096;

  // line store: rings of (MAX_TAPS-1) rows
  localparam int LINE_DEPTH = (MAX_TAPS - 1) * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int TAP_W      = $clog2(MAX_TAPS);
  localparam int R_MAX      = (MAX_TAPS - 1) / 2;

  // field widths
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int RAD_W  = 3;
  localparam int SLOT_W = 4;
  localparam int COEF_W = 16;
  localparam int PIX_W  = 8;
  localparam int SM_W   = 16;
  localparam int DER_W  = 18;
  localparam int DATA_W = 16;

  // positions and derived geometry
  localparam int POS_W  = 23;
  localparam int ROW_W  = POS_W + 1;
  localparam int COL_W  = WID_W + 1;
  localparam int RW_W   = RAD_W + WID_W;
  localparam int PROD_W = SM_W + 1 + COEF_W;
  localparam int ACC_W  = PROD_W + TAP_W + 1;
  localparam int DCNT_W = $clog2(POS_W);

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_SLOT   = 3'd3,
    CFG_SMOOTH = 3'd4,
    CFG_SLOPE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_GEOM,
    ST_CHECK,
    ST_POS,
    ST_RUN,
    ST_FLUSH,
    ST_RND_A,
    ST_RND_B,
    ST_FIN
  } state_t;

  // raster position as row and column
  typedef struct packed {
    logic signed [ROW_W-1:0] row;
    logic [WID_W-1:0]        col;
  } rc_t;

endpackage

@@ design/separable_gaussian_gradient.sv @@
`timescale 1ns / 1ps
// separable_gaussian_gradient: streaming Gaussian-derivative gradient (top level).
// Depends on sgg_pkg.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_ready, in_operation, in_pixel_value | in
//  result  | out_valid, out_ready, out_col_deriv,         | out
//          | out_row_deriv, out_frame_done                |
//  config  | cfg_we, cfg_index, cfg_data                  | in
//
// The tap sequencer runs each transaction as two passes of 2*R+1 taps (R = effective
// kernel radius), each through a three-stage read / multiply / accumulate pipe, one
// line-store read per pass per cycle. The first transaction after a frame_width
// write also passes through ST_DIV: the row and column of the input position are
// re-derived by a bit-serial divider.
// Reset (rst_n low, synchronous) clears control, registers, tables and windows;
// the line stores are not cleared. A result waiting in the output register does
// not block the next input transaction; only the final write-back waits for it.
module separable_gaussian_gradient (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [sgg_pkg::PIX_W-1:0]         in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sgg_pkg::DER_W-1:0]  out_col_deriv,
  output logic signed [sgg_pkg::DER_W-1:0]  out_row_deriv,
  output logic                              out_frame_done,
  input  logic                              cfg_we,
  input  logic [sgg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgg_pkg::DATA_W-1:0]        cfg_data
);
  import sgg_pkg::*;

  // ---------------------------------------------------------------- config
  logic [WID_W-1:0]  width_r;
  logic [HGT_W-1:0]  height_r;
  logic [RAD_W-1:0]  radius_r;
  logic [SLOT_W-1:0] slot_r;
  logic signed [COEF_W-1:0] smooth_tab_r [MAX_TAPS];
  logic signed [COEF_W-1:0] slope_tab_r  [MAX_TAPS];
  logic dirty_r;  // frame_width changed: row/column must be re-derived

  // effective geometry (clamped)
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [RAD_W-1:0] r_eff;
  logic [TAP_W-1:0] two_r;

  always_comb begin
    if (width_r == '0) w_eff = WID_W'(1);
    else if (width_r > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == '0) h_eff = HGT_W'(1);
    else if (height_r > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else h_eff = height_r;
    if (radius_r > RAD_W'(R_MAX)) r_eff = RAD_W'(R_MAX);
    else r_eff = radius_r;
    two_r = TAP_W'({r_eff, 1'b0});
  end

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  // position of the input stream
  logic [POS_W-1:0]  t_r;       // transactions taken in this frame
  logic [ADDR_W-1:0] tmod_r;    // t modulo line-store depth
  logic [POS_W-1:0]  row_t_r;
  logic [WID_W-1:0]  col_t_r;

  // derived geometry
  logic [POS_W-1:0]  n_r;       // pixels per frame
  logic [RW_W-1:0]   rw_r;      // R*W
  logic [RW_W:0]     d_r;       // R*W + R
  logic [RW_W:0]     tw2_r;     // 2*R*W

  // item context
  logic              op_r;
  logic [PIX_W-1:0]  pix_r;
  logic [PIX_W-1:0]  cur_r;
  logic              draining_r, u_valid_r, s_valid_r, q_valid_r, q_last_r;
  logic [ADDR_W-1:0] umod_r;
  logic signed [ROW_W-1:0] iq_r;
  logic [WID_W-1:0]  jq_r;
  logic [SM_W-1:0]   hs_new_r;
  logic signed [DER_W-1:0] res_col_r, res_row_r;

  // tap sequencer
  logic              phase_b_r;
  logic [TAP_W-1:0]  k_r;
  logic              fl_r;
  logic [ADDR_W-1:0] addr_r;
  logic signed [COL_W-1:0] xpos_r;
  logic signed [ROW_W-1:0] ypos_r;
  logic              xv_r, yv_r;

  // MAC pipe
  logic              s1_v_r, s2_v_r;
  logic [SM_W-1:0]   s1_xop_r;
  logic              s1_yen_r, s1_ydir_r;
  logic signed [COEF_W-1:0] s1_coef_r;
  logic signed [PROD_W-1:0] px_r, py_r;
  logic signed [ACC_W-1:0]  accx_r, accy_r;

  // windows
  logic [PIX_W-1:0] raw_win_r [MAX_TAPS];
  logic [SM_W-1:0]  vs_win_r  [MAX_TAPS];

  // divider
  logic [POS_W-1:0]  quo_r;
  logic [WID_W-1:0]  rem_r;
  logic [DCNT_W-1:0] dcnt_r;

  // line stores
  logic [PIX_W-1:0] raw_mem [LINE_DEPTH];
  logic [SM_W-1:0]  hs_mem  [LINE_DEPTH];
  logic [PIX_W-1:0] raw_q;
  logic [SM_W-1:0]  hs_q;

  logic out_valid_r;

  // ---------------------------------------------------------------- helpers
  // step a raster position back by n pixels (n <= R_MAX)
  function automatic rc_t back_step(rc_t p, logic [RAD_W-1:0] n, logic [WID_W-1:0] w);
    rc_t q;
    q = p;
    for (int i = 0; i < R_MAX; i++) begin
      if (i < int'(n)) begin
        if (q.col == '0) begin
          q.col = w - WID_W'(1);
          q.row = q.row - ROW_W'(1);
        end else begin
          q.col = q.col - WID_W'(1);
        end
      end
    end
    return q;
  endfunction

  // Q.15 sum to unsigned Q8.8
  function automatic logic [SM_W-1:0] smooth_round(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] sh;
    v  = (ACC_W+1)'(acc) + (ACC_W+1)'(64);
    sh = v >>> 7;
    if (v < 0) return '0;
    else if (sh > (ACC_W+1)'(65535)) return {SM_W{1'b1}};
    else return sh[SM_W-1:0];
  endfunction

  // Q.23 sum to signed Q9.8, rounded, saturated
  function automatic logic signed [DER_W-1:0] deriv_round(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] sh;
    v  = (ACC_W+1)'(acc) + (ACC_W+1)'(16384);
    sh = v >>> 15;
    if (sh > (ACC_W+1)'(131071)) return DER_W'(131071);
    else if (sh < -(ACC_W+1)'(131072)) return DER_W'(-131072);
    else return sh[DER_W-1:0];
  endfunction

  // ---------------------------------------------------------------- combinational
  logic [RAD_W+WID_W-1:0] rw_c;
  logic [POS_W:0]  n_ext, t_ext;
  logic            lim_hit, draining_c, ignore_c;
  logic            u_ok, s_ok, q_ok, q_last_c;
  rc_t             pos_u, pos_q, pos_s;
  logic signed [ADDR_W:0] umod_d, rbase_d, hbase_d;
  logic [ADDR_W-1:0] umod_c, rbase_c, hbase_c;
  logic [ADDR_W:0]   addr_sum;
  logic [ADDR_W-1:0] addr_step;
  logic [TAP_W-1:0]  widx;
  logic signed [COL_W-1:0] xcol;
  logic signed [ROW_W-1:0] yrow;
  logic            xok, yok;
  logic [SM_W-1:0] yop;
  logic [SM_W-1:0] ydir;
  logic [2*HGT_W-1:0] wh;
  logic            div_last;
  logic [WID_W:0]  rem_sh;
  logic            rem_ge;
  logic [WID_W:0]  rem_sub;
  logic            fin_go;
  logic            load_out;

  always_comb begin
    rw_c  = (RAD_W+WID_W)'(r_eff) * (RAD_W+WID_W)'(w_eff);
    wh    = (2*HGT_W)'(w_eff) * (2*HGT_W)'(h_eff);
    n_ext = {1'b0, n_r};
    t_ext = {1'b0, t_r};

    lim_hit    = t_ext >= n_ext + (POS_W+1)'(d_r);
    draining_c = t_r >= n_r;
    ignore_c   = op_r && !draining_c;
    u_ok       = (t_ext >= (POS_W+1)'(r_eff)) && (t_ext < n_ext + (POS_W+1)'(r_eff));
    s_ok       = (t_ext >= (POS_W+1)'(rw_r)) && (t_ext < n_ext + (POS_W+1)'(rw_r));
    q_ok       = (t_ext >= (POS_W+1)'(d_r)) && (t_ext < n_ext + (POS_W+1)'(d_r));
    q_last_c   = t_ext == n_ext + (POS_W+1)'(d_r) - (POS_W+1)'(1);

    pos_u = back_step('{row: ROW_W'(row_t_r), col: col_t_r}, r_eff, w_eff);
    pos_s = '{row: ROW_W'(row_t_r) - ROW_W'(r_eff), col: col_t_r};
    pos_q = back_step(pos_s, r_eff, w_eff);

    // ring addresses, one wrap at most
    umod_d  = $signed({1'b0, tmod_r}) - $signed((ADDR_W+1)'(r_eff));
    umod_c  = umod_d[ADDR_W] ? ADDR_W'(umod_d + (ADDR_W+1)'(LINE_DEPTH)) : umod_d[ADDR_W-1:0];
    rbase_d = $signed({1'b0, tmod_r}) - $signed((ADDR_W+1)'(tw2_r));
    rbase_c = rbase_d[ADDR_W] ? ADDR_W'(rbase_d + (ADDR_W+1)'(LINE_DEPTH))
                              : rbase_d[ADDR_W-1:0];
    hbase_d = $signed({1'b0, umod_r}) - $signed((ADDR_W+1)'(tw2_r));
    hbase_c = hbase_d[ADDR_W] ? ADDR_W'(hbase_d + (ADDR_W+1)'(LINE_DEPTH))
                              : hbase_d[ADDR_W-1:0];
    addr_sum  = {1'b0, addr_r} + (ADDR_W+1)'(w_eff);
    addr_step = (addr_sum >= (ADDR_W+1)'(LINE_DEPTH))
              ? ADDR_W'(addr_sum - (ADDR_W+1)'(LINE_DEPTH)) : addr_sum[ADDR_W-1:0];

    // tap issue
    widx = two_r - k_r;
    xcol = xpos_r + COL_W'(k_r);
    yrow = ypos_r + ROW_W'(k_r);
    xok  = xv_r && !xcol[COL_W-1] && (xcol[COL_W-2:0] < w_eff);
    yok  = yv_r && !yrow[ROW_W-1] && (yrow[ROW_W-2:0] < POS_W'(h_eff));

    // second pipe stage operand
    ydir = phase_b_r ? hs_new_r : SM_W'(cur_r);
    if (!s1_yen_r) yop = '0;
    else if (s1_ydir_r) yop = ydir;
    else if (phase_b_r) yop = hs_q;
    else yop = SM_W'(raw_q);

    // bit-serial divide of t by width
    div_last = dcnt_r == DCNT_W'(POS_W - 1);
    rem_sh   = {rem_r, quo_r[POS_W-1]};
    rem_ge   = rem_sh >= (WID_W+1)'(w_eff);
    rem_sub  = rem_ge ? rem_sh - (WID_W+1)'(w_eff) : rem_sh;

    fin_go   = !q_valid_r || !out_valid_r || out_ready;
    load_out = (state_r == ST_FIN) && fin_go && q_valid_r;
  end

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = dirty_r ? ST_DIV : ST_GEOM;
      ST_DIV:   if (div_last) state_nxt = ST_GEOM;
      ST_GEOM:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_POS;
      ST_POS:   state_nxt = ignore_c ? ST_IDLE : ST_RUN;
      ST_RUN:   if (k_r == two_r) state_nxt = ST_FLUSH;
      ST_FLUSH: if (fl_r) state_nxt = phase_b_r ? ST_RND_B : ST_RND_A;
      ST_RND_A: state_nxt = ST_RUN;
      ST_RND_B: state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= WID_W'(640);
      height_r    <= HGT_W'(480);
      radius_r    <= RAD_W'(2);
      slot_r      <= '0;
      dirty_r     <= 1'b0;
      t_r         <= '0;
      tmod_r      <= '0;
      row_t_r     <= '0;
      col_t_r     <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        smooth_tab_r[i] <= '0;
        slope_tab_r[i]  <= '0;
        raw_win_r[i]    <= '0;
        vs_win_r[i]     <= '0;
      end
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= state_r == ST_RUN;
      s2_v_r  <= s1_v_r;

      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WIDTH: begin
            width_r <= cfg_data[WID_W-1:0];
            dirty_r <= 1'b1;
          end
          CFG_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
          CFG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
          CFG_SLOT:   slot_r   <= cfg_data[SLOT_W-1:0];
          CFG_SMOOTH: if (slot_r < SLOT_W'(MAX_TAPS)) smooth_tab_r[TAP_W'(slot_r)] <= cfg_data;
          CFG_SLOPE:  if (slot_r < SLOT_W'(MAX_TAPS)) slope_tab_r[TAP_W'(slot_r)]  <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: dcnt_r <= '0;
        ST_DIV: begin
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (div_last) begin
            row_t_r <= {quo_r[POS_W-2:0], rem_ge};
            col_t_r <= rem_sub[WID_W-1:0];
            dirty_r <= 1'b0;
          end
        end
        ST_CHECK: begin
          // position past the last drain item: restart the frame
          if (lim_hit) begin
            t_r     <= '0;
            tmod_r  <= '0;
            row_t_r <= '0;
            col_t_r <= '0;
          end
        end
        ST_POS: begin
          if (!ignore_c) begin
            raw_win_r[0] <= draining_c ? '0 : pix_r;
            for (int i = 1; i < MAX_TAPS; i++) raw_win_r[i] <= raw_win_r[i-1];
          end
        end
        ST_RND_A: begin
          vs_win_r[0] <= s_valid_r ? smooth_round(accy_r) : '0;
          for (int i = 1; i < MAX_TAPS; i++) vs_win_r[i] <= vs_win_r[i-1];
        end
        ST_FIN: begin
          if (fin_go) begin
            if (q_valid_r && q_last_r) begin
              t_r     <= '0;
              tmod_r  <= '0;
              row_t_r <= '0;
              col_t_r <= '0;
            end else begin
              t_r    <= t_r + POS_W'(1);
              tmod_r <= (tmod_r == ADDR_W'(LINE_DEPTH - 1)) ? '0 : tmod_r + ADDR_W'(1);
              if (col_t_r + WID_W'(1) == w_eff) begin
                col_t_r <= '0;
                row_t_r <= row_t_r + POS_W'(1);
              end else begin
                col_t_r <= col_t_r + WID_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk) begin
    // MAC pipe: issue -> multiply -> accumulate
    s1_xop_r  <= xok ? (phase_b_r ? vs_win_r[widx] : SM_W'(raw_win_r[widx])) : '0;
    s1_yen_r  <= yok;
    s1_ydir_r <= k_r == two_r;
    s1_coef_r <= phase_b_r ? slope_tab_r[k_r] : smooth_tab_r[k_r];
    px_r <= PROD_W'($signed({1'b0, s1_xop_r}) * s1_coef_r);
    py_r <= PROD_W'($signed({1'b0, yop}) * s1_coef_r);
    if (s2_v_r) begin
      accx_r <= accx_r + ACC_W'(px_r);
      accy_r <= accy_r + ACC_W'(py_r);
    end

    case (state_r)
      ST_IDLE: begin
        op_r  <= in_operation;
        pix_r <= in_pixel_value;
        quo_r <= t_r;
        rem_r <= '0;
      end
      ST_DIV: begin
        quo_r <= {quo_r[POS_W-2:0], rem_ge};
        rem_r <= rem_sub[WID_W-1:0];
      end
      ST_GEOM: begin
        n_r   <= wh[POS_W-1:0];
        rw_r  <= rw_c;
        d_r   <= (RW_W+1)'(rw_c) + (RW_W+1)'(r_eff);
        tw2_r <= {rw_c, 1'b0};
      end
      ST_POS: begin
        draining_r <= draining_c;
        cur_r      <= draining_c ? '0 : pix_r;
        u_valid_r  <= u_ok;
        s_valid_r  <= s_ok;
        q_valid_r  <= q_ok;
        q_last_r   <= q_last_c;
        umod_r     <= umod_c;
        iq_r       <= pos_q.row;
        jq_r       <= pos_q.col;
        // horizontal smoothing of t-R, vertical smoothing of t-R*W
        xpos_r     <= $signed(COL_W'(pos_u.col)) - $signed(COL_W'(r_eff));
        ypos_r     <= pos_s.row - ROW_W'(r_eff);
        xv_r       <= u_ok;
        yv_r       <= s_ok;
        addr_r     <= rbase_c;
        phase_b_r  <= 1'b0;
        k_r        <= '0;
        accx_r     <= '0;
        accy_r     <= '0;
      end
      ST_RUN: begin
        k_r    <= k_r + TAP_W'(1);
        addr_r <= addr_step;
        fl_r   <= 1'b0;
      end
      ST_FLUSH: fl_r <= 1'b1;
      ST_RND_A: begin
        hs_new_r  <= u_valid_r ? smooth_round(accx_r) : '0;
        // derivatives of output position t-D
        xpos_r    <= $signed(COL_W'(jq_r)) - $signed(COL_W'(r_eff));
        ypos_r    <= iq_r - ROW_W'(r_eff);
        xv_r      <= q_valid_r;
        yv_r      <= q_valid_r;
        addr_r    <= hbase_c;
        phase_b_r <= 1'b1;
        k_r       <= '0;
        accx_r    <= '0;
        accy_r    <= '0;
      end
      ST_RND_B: begin
        res_col_r <= deriv_round(accy_r);
        res_row_r <= deriv_round(accx_r);
      end
      default: ;
    endcase

    if (load_out) begin
      out_col_deriv  <= res_col_r;
      out_row_deriv  <= res_row_r;
      out_frame_done <= q_last_r;
    end
  end

  // line stores: one read port and one write port each, registered read
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && fin_go && !draining_r) raw_mem[tmod_r] <= cur_r;
    raw_q <= raw_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && fin_go && u_valid_r) hs_mem[umod_r] <= hs_new_r;
    hs_q <= hs_mem[addr_r];
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------- assertions
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r <= two_r))
    else $error("tap counter beyond kernel");

  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    tmod_r < ADDR_W'(LINE_DEPTH))
    else $error("ring pointer beyond line store");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !dirty_r) |-> (col_t_r < w_eff))
    else $error("column counter out of step with width");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result not presented");

  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND_A || state_r == ST_RND_B) |-> (!s1_v_r && !s2_v_r))
    else $error("rounding before MAC pipe drained");

endmodule
